@@ design/htwd_pkg.sv @@
`default_nettype none
package htwd_pkg;

  // field widths
  localparam int IDX_W = 6;
  localparam int SYM_W = 8;
  localparam int CNT_W = 32;
  localparam int BYTE_W = 8;
  localparam int CFG_DATA_W = 32;

  // walk step counter: steps 0..7 issue a read, steps 1..8 check a node
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_DECODE = 2'd2
  } opcode_t;

  typedef enum logic {
    CFG_ROOT_INDEX  = 1'b0,
    CFG_MAX_SYMBOLS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] symbol;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // commands from controller to datapath
  typedef struct packed {
    logic do_load;
    logic do_start;
    logic do_decode;
    logic fetch;
    logic issue;
    logic eval;
    logic flush;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

@@ design/huffman_tree_walk_decoder.sv @@
// load and start words leave busy low and the next word may follow at once
// a decode word keeps busy high through the fetch, walk and flush states, so no new byte is taken before then
// its symbols appear one per cycle at most, the last one flagged
// the walk makes one dependent node table read per bit through the registered ram port
// rst_n is synchronous: it clears walk position and symbol count, sets root index to zero and max symbols to all ones
// the node table is not cleared; results cannot be stalled by the receiver
`default_nettype none
module huffman_tree_walk_decoder
  import htwd_pkg::*;
#(
  parameter int NODE_COUNT = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_opcode,
  input  wire logic [IDX_W-1:0]      in_node_index,
  input  wire logic [IDX_W-1:0]      in_node_left,
  input  wire logic [IDX_W-1:0]      in_node_right,
  input  wire logic [SYM_W-1:0]      in_node_symbol,
  input  wire logic [BYTE_W-1:0]     in_data_byte,
  output logic                       out_valid,
  output logic [SYM_W-1:0]           out_symbol,
  output logic                       out_last,
  output logic [CNT_W-1:0]           out_emitted_count,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;

  htwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .busy      (busy),
    .cmd       (cmd)
  );

  htwd_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_node_index     (in_node_index),
    .in_node_left      (in_node_left),
    .in_node_right     (in_node_right),
    .in_node_symbol    (in_node_symbol),
    .in_data_byte      (in_data_byte),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_symbol        (out_symbol),
    .out_last          (out_last),
    .out_emitted_count (out_emitted_count)
  );

`ifndef SYNTHESIS
  // a result word only follows a cycle of decode work
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word outside a decode");

  // an accepted decode word keeps the block busy
  a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_DECODE) |=> busy)
    else $error("decode word did not start a walk");

  // emitted symbols are leaves and the count never reads zero
  a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_symbol != '0 && out_emitted_count != '0))
    else $error("result word with zero symbol or count");
`endif

endmodule
`default_nettype wire

@@ design/htwd_ram.sv @@
`default_nettype none
module htwd_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ design/htwd_ctrl.sv @@
`default_nettype none
module htwd_ctrl
  import htwd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_opcode,
  output logic            busy,
  output ctrl_cmd_t       cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;

  assign accept = start && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_opcode == OP_DECODE) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_WALK;
        step_nxt  = '0;
      end
      ST_WALK: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FLUSH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.do_load   = accept && in_opcode == OP_LOAD;
        cmd.do_start  = accept && in_opcode == OP_START;
        cmd.do_decode = accept && in_opcode == OP_DECODE;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_WALK: begin
        cmd.issue = step_r != LAST_STEP;
        cmd.eval  = step_r != '0;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/htwd_datapath.sv @@
`default_nettype none
module htwd_datapath
  import htwd_pkg::*;
#(
  parameter int NODE_COUNT = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctrl_cmd_t             cmd,
  input  wire logic [IDX_W-1:0]      in_node_index,
  input  wire logic [IDX_W-1:0]      in_node_left,
  input  wire logic [IDX_W-1:0]      in_node_right,
  input  wire logic [SYM_W-1:0]      in_node_symbol,
  input  wire logic [BYTE_W-1:0]     in_data_byte,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  output logic [SYM_W-1:0]           out_symbol,
  output logic                       out_last,
  output logic [CNT_W-1:0]           out_emitted_count
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // configuration
  logic [IDX_W-1:0] root_index_r;
  logic [CNT_W-1:0] max_symbols_r;

  // walk state
  logic [IDX_W-1:0]  current_node_r, current_node_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [IDX_W-1:0]  child_prev_r;
  node_t             root_data_r;
  logic              range_a_r, range_b_r;

  // held result and output word
  logic              pend_v_r, pend_v_nxt;
  logic [SYM_W-1:0]  pend_sym_r;
  logic [CNT_W-1:0]  pend_cnt_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  out_symbol_r, out_symbol_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  // memory ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [NODE_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;
  logic [IDX_W-1:0]  addr_a;

  node_t            a_node, b_node, cur;
  logic             below, emit;
  logic [IDX_W-1:0] child;
  logic [CNT_W-1:0] count_inc;

  // node table write on load, indexes beyond the table are dropped
  assign ram_we    = cmd.do_load && (32'(in_node_index) < 32'(NODE_COUNT));
  assign ram_waddr = AW'(in_node_index);
  assign ram_wdata = {in_node_left, in_node_right, in_node_symbol};

  // read data, a node beyond the table reads as all zero
  assign a_node = range_a_r ? node_t'(ram_rdata_a) : '0;
  assign b_node = range_b_r ? node_t'(ram_rdata_b) : '0;

  // leaf check for the node reached by the previous bit
  assign below     = count_r < max_symbols_r;
  assign emit      = cmd.eval && (a_node.symbol != '0) && below;
  assign count_inc = count_r + 1'b1;

  // node the next bit starts from
  assign cur   = emit ? root_data_r : a_node;
  assign child = data_r[BYTE_W-1] ? cur.right : cur.left;

  assign addr_a      = cmd.fetch ? current_node_r : child;
  assign ram_raddr_a = AW'(addr_a);
  assign ram_raddr_b = AW'(root_index_r);

  htwd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // walk and stream count update
  always_comb begin
    current_node_nxt = current_node_r;
    count_nxt        = count_r;
    data_nxt         = data_r;
    if (cmd.do_start) begin
      current_node_nxt = root_index_r;
      count_nxt        = '0;
    end
    if (cmd.do_decode) begin
      data_nxt = in_data_byte;
    end
    if (cmd.issue) begin
      data_nxt = {data_r[BYTE_W-2:0], 1'b0};
    end
    if (cmd.eval) begin
      current_node_nxt = emit ? root_index_r : child_prev_r;
    end
    if (emit) begin
      count_nxt = count_inc;
    end
  end

  // a symbol is held until the next one or the end of the byte marks it
  always_comb begin
    pend_v_nxt     = pend_v_r;
    out_valid_nxt  = 1'b0;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;
    if (emit) begin
      pend_v_nxt = 1'b1;
      if (pend_v_r) begin
        out_valid_nxt  = 1'b1;
        out_symbol_nxt = pend_sym_r;
        out_last_nxt   = 1'b0;
        out_count_nxt  = pend_cnt_r;
      end
    end
    if (cmd.flush && pend_v_r) begin
      pend_v_nxt     = 1'b0;
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = pend_sym_r;
      out_last_nxt   = 1'b1;
      out_count_nxt  = pend_cnt_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_index_r   <= '0;
      max_symbols_r  <= '1;
      current_node_r <= '0;
      count_r        <= '0;
      pend_v_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_ROOT_INDEX) begin
        root_index_r <= cfg_data[IDX_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_MAX_SYMBOLS) begin
        max_symbols_r <= cfg_data[CNT_W-1:0];
      end
      current_node_r <= current_node_nxt;
      count_r        <= count_nxt;
      pend_v_r       <= pend_v_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    data_r       <= data_nxt;
    range_a_r    <= 32'(addr_a) < 32'(NODE_COUNT);
    range_b_r    <= 32'(root_index_r) < 32'(NODE_COUNT);
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
    if (cmd.issue) begin
      child_prev_r <= child;
    end
    if (cmd.issue && !cmd.eval) begin
      root_data_r <= b_node;
    end
    if (emit) begin
      pend_sym_r <= a_node.symbol;
      pend_cnt_r <= count_inc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_symbol        = out_symbol_r;
  assign out_last          = out_last_r;
  assign out_emitted_count = out_count_r;

endmodule
`default_nettype wire
